@@ design/huffman_tree_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree stream decoder
// Shared forms of the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_STREAM_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HTSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HTSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/htsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_pkg
// Types, constants and helpers shared by the Huffman stream decoder.
// ----------------------------------------------------------------------------
package htsd_pkg;

    localparam int IDX_W    = 9;
    localparam int NODE_W   = 19;
    localparam int LEAF_BIT = 18;

    // File phase, advanced once per byte
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_PAD,
        PH_TREE,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TREE,
        ST_POP,
        ST_BODY,
        ST_END
    } state_t;

    // One queued input byte
    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } q_item_t;

    // One result transfer
    typedef struct packed {
        logic [7:0] sym;
        logic       valid;
        logic       last;
        logic       done;
        logic       err;
    } res_t;

    // Number of trailing ones of the padding mask (0 to 8)
    function automatic logic [3:0] pad_count(input logic [7:0] mask);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run && mask[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

@@ design/htsd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/htsd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_front
// Input side: accepts byte transfers into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module htsd_front
    import htsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // final_byte
    output logic       q_valid,
    output q_item_t    q_item,
    input  logic       q_ready
);

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{fin: s_tlast, data: s_tdata};
        end
    end

endmodule

@@ design/htsd_back.sv @@
`timescale 1ns / 1ps
`include "huffman_tree_stream_decoder_assert.svh"
// ----------------------------------------------------------------------------
// htsd_back
// Bit sequencer: builds the node table from the header tree, walks it over
// the body bits and drives the result register.
// ----------------------------------------------------------------------------
module htsd_back
    import htsd_pkg::*;
#(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  q_item_t                        q_item,
    output logic                           q_ready,
    output logic                           node_we,
    output logic [$clog2(NODE_DEPTH)-1:0]  node_waddr,
    output logic [NODE_W-1:0]              node_wdata,
    output logic                           node_re,
    output logic [$clog2(NODE_DEPTH)-1:0]  node_raddr,
    input  logic [NODE_W-1:0]              node_rdata,
    output logic                           stack_we,
    output logic [$clog2(STACK_DEPTH)-1:0] stack_waddr,
    output logic [IDX_W-1:0]               stack_wdata,
    output logic                           stack_re,
    output logic [$clog2(STACK_DEPTH)-1:0] stack_raddr,
    input  logic [IDX_W-1:0]               stack_rdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);

    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int NCW = $clog2(NODE_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          byte_reg, byte_next;
    logic                fin_reg, fin_next;
    logic [2:0]          pos_reg, pos_next;
    logic [3:0]          nbits_reg, nbits_next;
    logic [3:0]          pad_low_reg, pad_low_next;
    logic [7:0]          sym_reg, sym_next;
    logic [3:0]          sym_left_reg, sym_left_next;
    logic [SCW-1:0]      stack_cnt_reg, stack_cnt_next;
    logic [NCW-1:0]      nodes_reg, nodes_next;
    logic [IDX_W-1:0]    top_idx_reg, top_idx_next;
    logic [NODE_W-1:0]   top_word_reg, top_word_next;
    logic [NODE_W-1:0]   root_word_reg, root_word_next;
    logic [NODE_W-1:0]   walk_word_reg, walk_word_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_sym_reg, pend_sym_next;
    logic                st_req_reg, st_req_next;
    logic                st_done_reg, st_done_next;
    logic                st_err_reg, st_err_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                out_free;
    logic [SCW-1:0]      cnt_m1, cnt_m2;
    logic                bit_in;
    logic [7:0]          sym_new;
    logic                adv, err, tdone, stall;
    logic [NODE_W-1:0]   cur;
    logic [IDX_W-1:0]    child;

    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m1   = stack_cnt_reg - SCW'(1);
    assign cnt_m2   = stack_cnt_reg - SCW'(2);
    assign bit_in   = byte_reg[pos_reg];
    assign sym_new  = {sym_reg[6:0], bit_in};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sym;
    assign m_tuser  = {out_reg.err, out_reg.done, out_reg.valid};
    assign m_tlast  = out_reg.last;

    // Sequencer: next state, memory controls and result staging
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        fin_next        = fin_reg;
        pos_next        = pos_reg;
        nbits_next      = nbits_reg;
        pad_low_next    = pad_low_reg;
        sym_next        = sym_reg;
        sym_left_next   = sym_left_reg;
        stack_cnt_next  = stack_cnt_reg;
        nodes_next      = nodes_reg;
        top_idx_next    = top_idx_reg;
        top_word_next   = top_word_reg;
        root_word_next  = root_word_reg;
        walk_word_next  = walk_word_reg;
        rd_pend_next    = rd_pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        st_req_next     = st_req_reg;
        st_done_next    = st_done_reg;
        st_err_next     = st_err_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        q_ready         = 1'b0;
        node_we         = 1'b0;
        node_waddr      = nodes_reg[NAW-1:0];
        node_wdata      = '0;
        node_re         = 1'b0;
        node_raddr      = '0;
        stack_we        = 1'b0;
        stack_waddr     = cnt_m1[SAW-1:0];
        stack_wdata     = top_idx_reg;
        stack_re        = 1'b0;
        stack_raddr     = cnt_m2[SAW-1:0];
        adv             = 1'b0;
        err             = 1'b0;
        tdone           = 1'b0;
        stall           = 1'b0;
        cur             = walk_word_reg;
        child           = '0;

        unique case (state_reg)
            // Take the next byte and sort it by file phase
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    byte_next   = q_item.data;
                    fin_next    = q_item.fin;
                    pos_next    = 3'd7;
                    st_req_next = 1'b0;
                    state_next  = ST_END;
                    unique case (phase_reg)
                        PH_COUNT: begin
                            stack_cnt_next = '0;
                            nodes_next     = '0;
                            sym_left_next  = 4'd0;
                            sym_next       = 8'd0;
                            if (q_item.fin) begin
                                st_req_next  = 1'b1;
                                st_done_next = 1'b1;
                                st_err_next  = 1'b1;
                            end else begin
                                phase_next = PH_PAD;
                            end
                        end
                        PH_PAD: begin
                            pad_low_next = pad_count(q_item.data);
                            if (q_item.fin) begin
                                st_req_next  = 1'b1;
                                st_done_next = 1'b1;
                                st_err_next  = 1'b1;
                                phase_next   = PH_COUNT;
                            end else begin
                                phase_next = PH_TREE;
                            end
                        end
                        PH_TREE: begin
                            state_next = ST_TREE;
                        end
                        PH_BODY: begin
                            state_next = ST_BODY;
                            nbits_next = q_item.fin ? (4'd8 - pad_low_reg) : 4'd8;
                            if (q_item.fin) begin
                                st_req_next  = 1'b1;
                                st_done_next = 1'b1;
                                st_err_next  = 1'b0;
                                phase_next   = PH_COUNT;
                            end
                        end
                        default: begin
                            if (q_item.fin) begin
                                st_req_next  = 1'b1;
                                st_done_next = 1'b1;
                                st_err_next  = 1'b0;
                                phase_next   = PH_COUNT;
                            end
                        end
                    endcase
                end
            end

            // One tree bit per cycle; a join bit also waits for the stack read in ST_POP
            ST_TREE: begin
                if (sym_left_reg != 4'd0) begin
                    sym_next      = sym_new;
                    sym_left_next = sym_left_reg - 4'd1;
                    if (sym_left_reg == 4'd1) begin
                        if (nodes_reg >= NCW'(NODE_DEPTH) ||
                            stack_cnt_reg >= SCW'(STACK_DEPTH)) begin
                            err = 1'b1;
                        end else begin
                            node_we        = 1'b1;
                            node_wdata     = {1'b1, 10'd0, sym_new};
                            stack_we       = (stack_cnt_reg != '0);
                            top_idx_next   = IDX_W'(nodes_reg);
                            top_word_next  = {1'b1, 10'd0, sym_new};
                            stack_cnt_next = stack_cnt_reg + SCW'(1);
                            nodes_next     = nodes_reg + NCW'(1);
                            adv            = 1'b1;
                        end
                    end else begin
                        adv = 1'b1;
                    end
                end else if (bit_in) begin
                    sym_left_next = 4'd8;
                    sym_next      = 8'd0;
                    adv           = 1'b1;
                end else if (stack_cnt_reg == SCW'(1)) begin
                    stack_cnt_next = '0;
                    if (top_word_reg[LEAF_BIT]) begin
                        err = 1'b1;
                    end else begin
                        root_word_next = top_word_reg;
                        walk_word_next = top_word_reg;
                        tdone          = 1'b1;
                    end
                end else if (stack_cnt_reg == '0) begin
                    err = 1'b1;
                end else begin
                    stack_re   = 1'b1;
                    state_next = ST_POP;
                end
            end

            // Left child arrives from the stack; join it with the top entry
            ST_POP: begin
                if (nodes_reg >= NCW'(NODE_DEPTH)) begin
                    err = 1'b1;
                end else begin
                    node_we        = 1'b1;
                    node_wdata     = {1'b0, stack_rdata, top_idx_reg};
                    top_idx_next   = IDX_W'(nodes_reg);
                    top_word_next  = {1'b0, stack_rdata, top_idx_reg};
                    stack_cnt_next = cnt_m1;
                    nodes_next     = nodes_reg + NCW'(1);
                    adv            = 1'b1;
                end
            end

            // Body walk: resolve last read, issue the next child read
            ST_BODY: begin
                if (rd_pend_reg) begin
                    if (node_rdata[LEAF_BIT]) begin
                        if (pend_valid_reg && !out_free) begin
                            stall = 1'b1;
                        end else begin
                            if (pend_valid_reg) begin
                                out_next       = '{sym: pend_sym_reg, valid: 1'b1,
                                                   last: 1'b0, done: 1'b0, err: 1'b0};
                                out_valid_next = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_sym_next   = node_rdata[7:0];
                            cur             = root_word_reg;
                        end
                    end else begin
                        cur = node_rdata;
                    end
                end
                if (!stall) begin
                    if (nbits_reg != 4'd0) begin
                        child        = bit_in ? cur[IDX_W-1:0] : cur[2*IDX_W-1:IDX_W];
                        node_re      = 1'b1;
                        node_raddr   = child[NAW-1:0];
                        rd_pend_next = 1'b1;
                        pos_next     = pos_reg - 3'd1;
                        nbits_next   = nbits_reg - 4'd1;
                    end else begin
                        rd_pend_next   = 1'b0;
                        walk_word_next = cur;
                        state_next     = ST_END;
                    end
                end
            end

            // End of byte: flush the held symbol or the status result
            ST_END: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_next        = '{sym: pend_sym_reg, valid: 1'b1, last: 1'b1,
                                            done: fin_reg, err: 1'b0};
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else if (st_req_reg) begin
                    if (out_free) begin
                        out_next       = '{sym: 8'd0, valid: 1'b0, last: 1'b1,
                                           done: st_done_reg, err: st_err_reg};
                        out_valid_next = 1'b1;
                        st_req_next    = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Tree bit outcome
        priority if (err) begin
            st_req_next  = 1'b1;
            st_err_next  = 1'b1;
            st_done_next = fin_reg;
            phase_next   = fin_reg ? PH_COUNT : PH_DISCARD;
            state_next   = ST_END;
        end else if (tdone) begin
            if (fin_reg) begin
                st_req_next  = 1'b1;
                st_done_next = 1'b1;
                st_err_next  = 1'b0;
                phase_next   = PH_COUNT;
            end else begin
                phase_next = PH_BODY;
            end
            state_next = ST_END;
        end else if (adv) begin
            if (pos_reg == 3'd0) begin
                if (fin_reg) begin
                    st_req_next  = 1'b1;
                    st_done_next = 1'b1;
                    st_err_next  = 1'b1;
                    phase_next   = PH_COUNT;
                end
                state_next = ST_END;
            end else begin
                pos_next   = pos_reg - 3'd1;
                state_next = ST_TREE;
            end
        end else begin
            // no tree bit finished this cycle
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_COUNT;
            pad_low_reg    <= 4'd0;
            sym_left_reg   <= 4'd0;
            stack_cnt_reg  <= '0;
            nodes_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            st_req_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pad_low_reg    <= pad_low_next;
            sym_left_reg   <= sym_left_next;
            stack_cnt_reg  <= stack_cnt_next;
            nodes_reg      <= nodes_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            st_req_reg     <= st_req_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        fin_reg       <= fin_next;
        pos_reg       <= pos_next;
        nbits_reg     <= nbits_next;
        sym_reg       <= sym_next;
        top_idx_reg   <= top_idx_next;
        top_word_reg  <= top_word_next;
        root_word_reg <= root_word_next;
        walk_word_reg <= walk_word_next;
        pend_sym_reg  <= pend_sym_next;
        st_done_reg   <= st_done_next;
        st_err_reg    <= st_err_next;
        out_reg       <= out_next;
    end

    `HTSD_ASSERT_IMPL(a_stack_bound, aclk, aresetn, 1'b1, stack_cnt_reg <= SCW'(STACK_DEPTH), "build stack count past depth")
    `HTSD_ASSERT_IMPL(a_node_bound, aclk, aresetn, 1'b1, nodes_reg <= NCW'(NODE_DEPTH), "node count past depth")
    `HTSD_ASSERT_IMPL(a_idle_no_pend, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg && !rd_pend_reg, "held symbol left over at byte fetch")
    `HTSD_ASSERT_IMPL(a_read_in_body, aclk, aresetn, rd_pend_reg, state_reg == ST_BODY, "node read outstanding outside body walk")
    `HTSD_ASSERT_NEXT(a_pop_follows, aclk, aresetn, state_reg == ST_POP, state_reg == ST_TREE || state_reg == ST_END, "pop step not resolved in one cycle")

endmodule

@@ design/huffman_tree_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder
// Huffman decoder for files that carry their code tree in the header.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one file byte per transfer, s_tlast marks the last byte.
//   m_* channel: results; m_tdata is the symbol, m_tuser holds
//   {format_error, stream_done, symbol_valid}, m_tlast closes the results of
//   one input byte. A byte may cause no result (header bytes, body bytes
//   with no leaf reached) or up to eight.
//   Each byte is fetched and then worked one bit per cycle by the back-end
//   sequencer while no tree-join bit waits on the build-stack read and the
//   result register is free. A full body byte runs fetch, eight node-table
//   reads, resolve of the last read and byte end; a tree-join bit adds a
//   stack-read step. Header count and pad bytes run only fetch and byte end.
//   The last symbol of a byte is held until the byte ends, so m_tlast and
//   stream_done ride on it; a two-entry input queue keeps taking bytes
//   while the sequencer works.
//   A stalled receiver (m_tready low) holds the result register and the
//   sequencer waits on its next result; the input queue then fills.
//   After reset the decoder expects a leaf count byte; node table and stack
//   memories need no clearing.
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder
    import htsd_pkg::*;
#(
    parameter int NODE_DEPTH  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] symbol
    output logic [2:0] m_tuser,   // [0] symbol_valid, [1] stream_done, [2] format_error
    output logic       m_tlast    // run_last
);

    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);

    logic              q_valid, q_ready;
    q_item_t           q_item;
    logic              node_we, node_re;
    logic [NAW-1:0]    node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic              stack_we, stack_re;
    logic [SAW-1:0]    stack_waddr, stack_raddr;
    logic [IDX_W-1:0]  stack_wdata, stack_rdata;

    // Input queue
    htsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    // Node table
    htsd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Build stack (entries below the top)
    htsd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Bit sequencer and result register
    htsd_back #(
        .NODE_DEPTH  (NODE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_ready     (q_ready),
        .node_we     (node_we),
        .node_waddr  (node_waddr),
        .node_wdata  (node_wdata),
        .node_re     (node_re),
        .node_raddr  (node_raddr),
        .node_rdata  (node_rdata),
        .stack_we    (stack_we),
        .stack_waddr (stack_waddr),
        .stack_wdata (stack_wdata),
        .stack_re    (stack_re),
        .stack_raddr (stack_raddr),
        .stack_rdata (stack_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman tree stream decoder: builds compressed
// files with random trees and bodies, predicts the decoded symbol stream and
// compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
    import htsd_pkg::*;

    localparam int NODE_CAP  = 512;
    localparam int STACK_CAP = 256;
    localparam int LIMIT     = 400000;

    typedef struct packed {
        logic [7:0] sym;
        logic       valid;
        logic       last;
        logic       done;
        logic       err;
    } outcome_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    huffman_tree_stream_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Decoder state mirror
    logic [18:0] dec_nodes [NODE_CAP];
    logic [8:0]  dec_stack [STACK_CAP];
    int          dec_depth = 0;
    int          dec_used = 0;
    phase_t      dec_phase = PH_COUNT;
    logic [7:0]  dec_pad = 8'd0;
    logic [7:0]  dec_partial = 8'd0;
    int          dec_bits_left = 0;
    logic [8:0]  dec_root = 9'd0;
    logic [8:0]  dec_walk = 9'd0;

    logic [8:0]  file_bytes [$];   // {fin, byte} waiting to be sent
    outcome_t    expected_q [$];
    outcome_t    step_out [$];

    int errors = 0;
    int cycles = 0;
    int n_bytes = 0;
    int n_results = 0;
    int n_files = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycles <= cycles + 1;

    function automatic logic [18:0] node_rd(logic [8:0] idx);
        return dec_nodes[idx];
    endfunction

    function automatic void push_out(logic [7:0] sym, logic v, logic d, logic e);
        outcome_t o;
        o.sym = sym; o.valid = v; o.last = 1'b0; o.done = d; o.err = e;
        step_out.push_back(o);
    endfunction

    // Add a node; 0 on overflow
    function automatic bit add_node(logic [18:0] word, bit is_leaf);
        if (dec_used >= NODE_CAP) return 0;
        if (is_leaf && dec_depth >= STACK_CAP) return 0;
        dec_nodes[dec_used] = word;
        dec_stack[dec_depth] = dec_used[8:0];
        dec_depth++;
        dec_used++;
        return 1;
    endfunction

    // Tree byte: 0 more tree, 1 complete, 2 error
    function automatic int tree_bits(logic [7:0] b);
        logic [8:0]  l, r;
        logic [18:0] rw;
        for (int pos = 7; pos >= 0; pos--) begin
            if (dec_bits_left > 0) begin
                dec_partial = {dec_partial[6:0], b[pos]};
                dec_bits_left--;
                if (dec_bits_left == 0)
                    if (!add_node({1'b1, 10'd0, dec_partial}, 1'b1)) return 2;
            end else if (b[pos]) begin
                dec_bits_left = 8;
                dec_partial = 8'd0;
            end else if (dec_depth == 1) begin
                dec_root = dec_stack[0];
                dec_depth = 0;
                rw = node_rd(dec_root);
                if (rw[18]) return 2;
                dec_walk = dec_root;
                return 1;
            end else if (dec_depth == 0) begin
                return 2;
            end else begin
                r = dec_stack[dec_depth-1];
                l = dec_stack[dec_depth-2];
                dec_depth -= 2;
                if (!add_node({1'b0, l, r}, 1'b0)) return 2;
            end
        end
        return 0;
    endfunction

    // Predict results of one accepted byte
    task automatic decode_byte(logic [7:0] b, logic fin);
        int res, low;
        logic [18:0] nd, cw;
        logic [8:0]  child;
        outcome_t    o;
        step_out.delete();
        case (dec_phase)
            PH_COUNT: begin
                dec_depth = 0; dec_used = 0; dec_bits_left = 0; dec_partial = 8'd0;
                if (fin) push_out(8'd0, 1'b0, 1'b1, 1'b1);
                else dec_phase = PH_PAD;
            end
            PH_PAD: begin
                dec_pad = b;
                if (fin) begin
                    push_out(8'd0, 1'b0, 1'b1, 1'b1);
                    dec_phase = PH_COUNT;
                end else dec_phase = PH_TREE;
            end
            PH_TREE: begin
                res = tree_bits(b);
                if (res == 2) begin
                    push_out(8'd0, 1'b0, fin, 1'b1);
                    dec_phase = fin ? PH_COUNT : PH_DISCARD;
                end else if (fin) begin
                    push_out(8'd0, 1'b0, 1'b1, res == 0);
                    dec_phase = PH_COUNT;
                end else if (res == 1) dec_phase = PH_BODY;
            end
            PH_BODY: begin
                low = 0;
                if (fin) while (low < 8 && dec_pad[low]) low++;
                for (int pos = 7; pos >= low; pos--) begin
                    nd = node_rd(dec_walk);
                    child = b[pos] ? nd[8:0] : nd[17:9];
                    cw = node_rd(child);
                    if (cw[18]) begin
                        if (step_out.size() < 8) push_out(cw[7:0], 1'b1, 1'b0, 1'b0);
                        dec_walk = dec_root;
                    end else dec_walk = child;
                end
                if (fin) begin
                    if (step_out.size() > 0) begin
                        o = step_out.pop_back(); o.done = 1'b1; step_out.push_back(o);
                    end else push_out(8'd0, 1'b0, 1'b1, 1'b0);
                    dec_phase = PH_COUNT;
                end
            end
            default: begin
                if (fin) begin
                    push_out(8'd0, 1'b0, 1'b1, 1'b0);
                    dec_phase = PH_COUNT;
                end
            end
        endcase
        if (step_out.size() > 0) begin
            o = step_out.pop_back(); o.last = 1'b1; step_out.push_back(o);
        end
        foreach (step_out[i]) expected_q.push_back(step_out[i]);
    endtask

    // ---------------- file generation ----------------
    logic        bitbuf [$];

    function automatic void put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
    endfunction

    // Random subtree serialized post-order; collects leaf codes
    logic [7:0]  code_sym [$];
    logic [15:0] code_val [$];
    int          code_len [$];

    function automatic void gen_tree(int n, logic [15:0] path, int plen);
        int k;
        if (n == 1 || plen >= 12) begin
            logic [7:0] s;
            s = 8'($urandom_range(0, 255));
            put_bits(32'd1, 1);
            put_bits(32'(s), 8);
            code_sym.push_back(s); code_val.push_back(path); code_len.push_back(plen);
            return;
        end
        k = $urandom_range(1, n - 1);
        gen_tree(k, {path[14:0], 1'b0}, plen + 1);
        gen_tree(n - k, {path[14:0], 1'b1}, plen + 1);
        put_bits(32'd0, 1);
    endfunction

    // Flush bitbuf to bytes (zero fill), marking fin on last
    function automatic void flush_bytes(bit fin_last);
        logic [7:0] b;
        while (bitbuf.size() > 0) begin
            b = '0;
            for (int i = 7; i >= 0; i--) b[i] = bitbuf.size() ? bitbuf.pop_front() : 1'b0;
            file_bytes.push_back({fin_last && bitbuf.size() == 0, b});
        end
    endfunction

    // Well-formed file with a random tree and body
    function automatic void make_file(int nleaves, int body_syms, int pad_bits);
        int  pick;
        logic [7:0] mask;
        code_sym.delete(); code_val.delete(); code_len.delete();
        bitbuf.delete();
        file_bytes.push_back({1'b0, 8'(nleaves)});
        // Low pad_bits ones, a zero above them, random bits higher up
        if (pad_bits == 8) begin
            mask = 8'hFF;
        end else begin
            mask = 8'($urandom) & ~(8'hFF >> (7 - pad_bits));
            mask = mask | (8'hFF >> (8 - pad_bits));
        end
        file_bytes.push_back({1'b0, mask});
        gen_tree(nleaves, 16'd0, 0);
        put_bits(32'd0, 1);
        flush_bytes(1'b0);
        for (int i = 0; i < body_syms; i++) begin
            pick = $urandom_range(0, code_sym.size() - 1);
            put_bits(32'(code_val[pick]), code_len[pick]);
        end
        // Body ends at the padding boundary; fill with random bits then pad
        if (pad_bits < 8) begin
            while ((bitbuf.size() + pad_bits) % 8 != 0)
                bitbuf.push_back(1'($urandom_range(0, 1)));
            for (int i = 0; i < pad_bits; i++) bitbuf.push_back(1'($urandom_range(0, 1)));
        end else begin
            while (bitbuf.size() % 8 != 0) bitbuf.push_back(1'($urandom_range(0, 1)));
            for (int i = 0; i < 8; i++) bitbuf.push_back(1'($urandom_range(0, 1)));
        end
        if (bitbuf.size() == 0) for (int i = 0; i < 8; i++) bitbuf.push_back(1'b0);
        flush_bytes(1'b1);
        n_files++;
    endfunction

    function automatic void push_byte(logic [7:0] b, logic fin);
        file_bytes.push_back({fin, b});
    endfunction

    // ---------------- driver ----------------
    int gap_in;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
            gap_in   <= 0;
        end else if (s_tvalid && !s_tready) begin
            // hold
        end else begin
            if (s_tvalid) begin
                decode_byte(s_tdata, s_tlast);
                n_bytes <= n_bytes + 1;
            end
            if (gap_in > 0) begin
                gap_in   <= gap_in - 1;
                s_tvalid <= 1'b0;
            end else if (file_bytes.size() > 0) begin
                logic [8:0] it;
                it = file_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it[7:0];
                s_tlast  <= it[8];
                gap_in   <= ($urandom_range(0, 3) == 0) ?
                            (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(1, 3)) : 0;
            end else s_tvalid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    int stall;
    always @(posedge aclk) begin
        outcome_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
                n_results <= n_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (stall > 0) begin
                stall    <= stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        aresetn  = 1'b0;

        // Directed: truncated files, empty body, errors, padding extremes
        push_byte(8'hFF, 1'b1);                                    // final count byte
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);            // final pad byte
        push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);                                    // underflow
        push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hBF, 1'b0); push_byte(8'hC0, 1'b1);            // leaf, then a truncated second leaf
        push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hA0, 1'b1);                                    // truncated tree
        make_file(2, 0, 0);
        make_file(2, 12, 8);
        make_file(2, 9, 0);
        make_file(5, 10, 3);
        make_file(40, 4, 1);

        // Random: mostly good files, some noise
        while (file_bytes.size() < 215 && n_files < 40) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
                push_byte(8'($urandom), 1'b1);
            end else begin
                make_file(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(2, 12),
                          $urandom_range(0, 30), $urandom_range(0, 8));
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while ((file_bytes.size() > 0 || s_tvalid || expected_q.size() > 0)
               && cycles < LIMIT) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (cycles >= LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        $display("Covered %0d input bytes in %0d files, %0d result transfers checked.",
                 n_bytes, n_files, n_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
